// ===== rtl/core/b58abi_pkg.sv =====
package b58abi_pkg;

    localparam int ACC_BYTES_DEF = 25;
    localparam int NUM_WORDS     = 5;
    localparam int NUM_PROBES    = 20;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_BAD = 2'd1;
    localparam logic [1:0] ST_OVF = 2'd2;

    localparam logic [4:0] PROBE_LAST = 5'(NUM_PROBES - 1);
    localparam logic [2:0] WORD_LAST  = 3'(NUM_WORDS - 1);

    typedef struct packed {
        logic       valid;
        logic [5:0] value;
    } digit_t;

    typedef struct packed {
        logic [1:0]                  status;
        logic [NUM_WORDS-1:0][31:0]  words;
    } job_t;

    function automatic digit_t b58_digit(input logic [7:0] code);
        digit_t d;
        d.valid = 1'b1;
        d.value = 6'd0;
        unique case (code) inside
            [8'h31:8'h39]: d.value = 6'(code - 8'h31);
            [8'h41:8'h48]: d.value = 6'(code - 8'h41 + 8'd9);
            [8'h4A:8'h4E]: d.value = 6'(code - 8'h4A + 8'd17);
            [8'h50:8'h5A]: d.value = 6'(code - 8'h50 + 8'd22);
            [8'h61:8'h6B]: d.value = 6'(code - 8'h61 + 8'd33);
            [8'h6D:8'h7A]: d.value = 6'(code - 8'h6D + 8'd44);
            default:       d.valid = 1'b0;
        endcase
        return d;
    endfunction

endpackage

// ===== rtl/core/b58abi_front.sv =====
module b58abi_front #(
    parameter int ACC_BYTES = b58abi_pkg::ACC_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              char_valid,
    output logic              char_ready,
    input  logic [7:0]        char_code,
    input  logic              last_char,
    output logic              push_valid,
    input  logic              push_ready,
    output b58abi_pkg::job_t  push_data
);
    import b58abi_pkg::*;

    localparam int AccW = ACC_BYTES * 8;

    logic [AccW-1:0] acc_reg, acc_next;
    logic            bad_reg, bad_next;
    logic            ovf_reg, ovf_next;
    logic [AccW+5:0] acc_ext;
    logic [AccW+5:0] prod;
    digit_t          dig;
    logic            accept;

    assign char_ready = push_ready;
    assign accept     = char_valid && char_ready;
    assign push_valid = char_valid && last_char;

    always_comb
    begin
        dig     = b58_digit(char_code);
        acc_ext = {6'd0, acc_reg};
        prod    = (acc_ext << 5) + (acc_ext << 4) + (acc_ext << 3) + (acc_ext << 1)
                + {{AccW{1'b0}}, dig.value};
        if (dig.valid)
        begin
            acc_next = prod[AccW-1:0];
        end
        else
        begin
            acc_next = acc_reg;
        end
        bad_next = bad_reg || !dig.valid;
        ovf_next = ovf_reg || (dig.valid && (|prod[AccW+5:AccW]));

        for (int k = 0; k < NUM_WORDS; k++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                push_data.words[k][8*j +: 8] = acc_next[AccW-1-8*(1+4*k+j) -: 8];
            end
        end
        if (bad_next)
        begin
            push_data.status = ST_BAD;
        end
        else if (ovf_next)
        begin
            push_data.status = ST_OVF;
        end
        else
        begin
            push_data.status = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            bad_reg <= 1'b0;
            ovf_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (last_char)
            begin
                acc_reg <= '0;
                bad_reg <= 1'b0;
                ovf_reg <= 1'b0;
            end
            else
            begin
                acc_reg <= acc_next;
                bad_reg <= bad_next;
                ovf_reg <= ovf_next;
            end
        end
    end

endmodule

// ===== rtl/core/b58abi_queue.sv =====
module b58abi_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  b58abi_pkg::job_t  push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output b58abi_pkg::job_t  pop_data
);
    import b58abi_pkg::*;

    localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    job_t            mem [QUEUE_DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0] count_reg;
    logic            do_push, do_pop;

    assign push_ready = count_reg != CntW'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/b58abi_back.sv =====
module b58abi_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  b58abi_pkg::job_t  pop_data,
    output logic              result_valid,
    input  logic              result_ready,
    output logic [1:0]        status,
    output logic [4:0]        probe_number,
    output logic [31:0]       bit_index,
    output logic              last_result
);
    import b58abi_pkg::*;

    job_t        job_reg;
    logic        busy_reg;
    logic [2:0]  k_reg;
    logic [1:0]  grp_reg;
    logic [4:0]  probe_reg;
    logic        valid_reg;
    logic [1:0]  status_reg;
    logic [4:0]  probe_out_reg;
    logic [31:0] index_reg;
    logic        last_reg;

    logic        advance, is_err, final_probe, take;
    logic [2:0]  k_nb;
    logic [31:0] wa, wb, value;

    always_comb
    begin
        advance     = busy_reg && (!valid_reg || result_ready);
        is_err      = job_reg.status != ST_OK;
        final_probe = is_err || (probe_reg == PROBE_LAST);
        take        = pop_valid && (!busy_reg || (advance && final_probe));
        k_nb        = (k_reg == WORD_LAST) ? 3'd0 : k_reg + 3'd1;
        wa          = job_reg.words[k_reg];
        wb          = job_reg.words[k_nb];
        case (grp_reg)
            2'd0:    value = wa;
            2'd1:    value = (wa << 16) | (wb >> 16);
            2'd2:    value = (wa << 8) | (wb >> 24);
            default: value = (wa << 24) | (wb >> 8);
        endcase
    end

    assign pop_ready    = take;
    assign result_valid = valid_reg;
    assign status       = status_reg;
    assign probe_number = probe_out_reg;
    assign bit_index    = index_reg;
    assign last_result  = last_reg;

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            job_reg <= pop_data;
        end
        if (advance)
        begin
            status_reg    <= job_reg.status;
            probe_out_reg <= is_err ? 5'd0 : probe_reg;
            index_reg     <= is_err ? 32'd0 : value;
            last_reg      <= final_probe;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
            k_reg     <= '0;
            grp_reg   <= '0;
            probe_reg <= '0;
        end
        else
        begin
            if (advance)
            begin
                valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                valid_reg <= 1'b0;
            end

            if (take)
            begin
                busy_reg  <= 1'b1;
                k_reg     <= '0;
                grp_reg   <= '0;
                probe_reg <= '0;
            end
            else if (advance && final_probe)
            begin
                busy_reg <= 1'b0;
            end
            else if (advance)
            begin
                probe_reg <= probe_reg + 5'd1;
                k_reg     <= k_nb;
                if (k_reg == WORD_LAST)
                begin
                    grp_reg <= grp_reg + 2'd1;
                end
            end
        end
    end

endmodule

// ===== rtl/core/base58_address_bloom_indexer.sv =====
// Base58 address decoder that turns each address into Bloom filter bit indices.
// Characters arrive on the char channel, one byte per cycle, with last_char set
// on the final character of an address. Each legal character updates a 200-bit
// accumulator (value times 58 plus digit) in the same cycle it is accepted.
// At the end of a clean address the result channel gives 20 words, probes 0 to
// 19, with last_result on the final one. An address with an illegal character
// or a value too large gives a single error word instead.
// Characters are taken at one per cycle while the job queue has room. Results
// leave at one per cycle while result_ready is high, so one address takes 20
// words of the output port; that port sets the long-run rate for addresses of
// fewer than 20 characters. With the back end idle, after the last character
// is accepted the job is written into the two-entry queue, then loaded into the
// generator, and then the first result is loaded into the output register.
// A stall on the result channel holds the output word steady and backs up into
// the queue; once both queue entries are full, char_ready drops.
// Reset clears the accumulator, both error flags, the queue and all valid bits.
module base58_address_bloom_indexer #(
    parameter int ACC_BYTES = b58abi_pkg::ACC_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        char_valid,
    output logic        char_ready,
    input  logic [7:0]  char_code,
    input  logic        last_char,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [1:0]  status,
    output logic [4:0]  probe_number,
    output logic [31:0] bit_index,
    output logic        last_result
);
    import b58abi_pkg::*;

    logic push_valid, push_ready, pop_valid, pop_ready;
    job_t push_data, pop_data;

    b58abi_front #(
        .ACC_BYTES (ACC_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_code  (char_code),
        .last_char  (last_char),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    b58abi_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    b58abi_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_data     (pop_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .probe_number (probe_number),
        .bit_index    (bit_index),
        .last_result  (last_result)
    );

endmodule
